FILE: rtl/ssrc_pkg.sv
// Shared types, constants and codes for the stepper step-rate commander.
package ssrc_pkg;

    localparam int unsigned TIMER_CLOCK_HZ = 1000000;

    localparam int unsigned RPM_W   = 16;
    localparam int unsigned SPR_W   = 16;
    localparam int unsigned RATE_W  = 19;
    localparam int unsigned SETUP_W = 8;
    localparam int unsigned PER_W   = 17;
    localparam int unsigned HIGH_W  = 16;
    localparam int unsigned CFG_W   = 19;
    localparam int unsigned CFG_IDX_W = 2;

    // Divider word: wide enough for rpm times steps per revolution.
    localparam int unsigned DIV_W     = RPM_W + SPR_W;
    localparam int unsigned CLK_W     = $clog2(TIMER_CLOCK_HZ + 1);
    localparam int unsigned PER_SHIFT = DIV_W - CLK_W;
    localparam int unsigned STEP_W    = $clog2(DIV_W + 1);

    localparam int unsigned RPM_ROUND = 30;
    localparam int unsigned RPM_DIV   = 60;
    localparam int unsigned PER_MIN   = 2;
    localparam int unsigned PER_MAX   = 65536;

    // Division by 60 of a word below 2^32: drop two bits, then multiply by the
    // reciprocal of 15 scaled by 2^34, which is exact for every 30-bit value.
    localparam int unsigned RECIP_PRE   = 2;
    localparam int unsigned RECIP_W     = 31;
    localparam int unsigned RECIP_15    = 1145324613;
    localparam int unsigned RECIP_SHIFT = 34;
    localparam int unsigned QPROD_W     = DIV_W - RECIP_PRE + RECIP_W;
    localparam int unsigned QUO_W       = QPROD_W - RECIP_SHIFT;

    localparam int unsigned SPR_RST   = 3200;
    localparam int unsigned MIN_RST   = 20;
    localparam int unsigned MAX_RST   = 8000;
    localparam int unsigned SETUP_RST = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP = 2'd3;

    typedef enum logic [1:0] {
        REQ_SPEED = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_HALT      = 3'd1,
        ACT_REVERSE   = 3'd2,
        ACT_COUNT     = 3'd3,
        ACT_PEND_TAKE = 3'd4,
        ACT_LAUNCH    = 3'd5
    } t_act;

    typedef struct packed {
        logic [1:0]       req_type;
        logic             direction;
        logic [RPM_W-1:0] rpm_req;
    } t_in_item;

    typedef struct packed {
        logic              pulse_enable;
        logic              dir_level;
        logic [PER_W-1:0]  period_ticks;
        logic [HIGH_W-1:0] high_ticks;
        logic              counter_cleared;
        logic              reversal_pending;
    } t_out_item;

    typedef struct packed {
        logic load_item;
        logic load_prod;
        logic load_quo;
        logic div_start;
        logic load_rate;
        t_act act;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic rate_zero;
        logic running;
        logic dir_diff;
        logic pend_valid;
        logic cnt_zero;
        logic div_busy;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/ssrc_in_if.sv
// Command channel: valid/ready handshake carrying one command item.
interface ssrc_in_if;
    import ssrc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ssrc_out_if.sv
// Result channel: valid/ready handshake carrying one drive-settings item.
interface ssrc_out_if;
    import ssrc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ssrc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module ssrc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ssrc_pkg::DIV_W-1:0]  i_dividend,
    input  logic [ssrc_pkg::DIV_W-1:0]  i_divisor,
    input  logic [ssrc_pkg::STEP_W-1:0] i_steps,
    output logic                        o_busy,
    output logic [ssrc_pkg::DIV_W-1:0]  o_quot
);
    import ssrc_pkg::*;

    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quot;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W:0]    rem_sh;
    logic [DIV_W:0]    diff;
    logic              ge;

    // The dividend sits left-aligned in the quotient register; its top bit
    // shifts into the remainder while the new quotient bit enters below.
    always_comb begin
        rem_sh = {r_rem, r_quot[DIV_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        ge     = ~diff[DIV_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[DIV_W-2:0], ge};
            r_rem  <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

FILE: rtl/ssrc_ctrl.sv
// Sequencer that steps each command through the shared datapath.
module ssrc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ssrc_pkg::t_dp_stat i_stat,
    output ssrc_pkg::t_dp_cmd  o_cmd
);
    import ssrc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_MUL      = 8'b0000_0100,
        S_DIV_RATE = 8'b0000_1000,
        S_DECIDE   = 8'b0001_0000,
        S_PEND     = 8'b0010_0000,
        S_DIV_PER  = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.act       = ACT_NONE;
        o_in_ready      = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.req)
                    REQ_SPEED: begin
                        o_cmd.load_prod = 1'b1;
                        n_state         = S_MUL;
                    end
                    REQ_TICK: begin
                        n_state = S_FIN;
                        if (i_stat.pend_valid) begin
                            if (i_stat.cnt_zero) begin
                                o_cmd.act = ACT_PEND_TAKE;
                                n_state   = S_PEND;
                            end else begin
                                o_cmd.act = ACT_COUNT;
                            end
                        end
                    end
                    REQ_STOP: begin
                        o_cmd.act = ACT_HALT;
                        n_state   = S_FIN;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.load_quo = 1'b1;
                n_state        = S_DIV_RATE;
            end
            S_DIV_RATE: begin
                o_cmd.load_rate = 1'b1;
                n_state         = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.rate_zero) begin
                    o_cmd.act = ACT_HALT;
                    n_state   = S_FIN;
                end else if (i_stat.running && i_stat.dir_diff) begin
                    o_cmd.act = ACT_REVERSE;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV_PER;
                end
            end
            S_PEND: begin
                if (i_stat.rate_zero) begin
                    o_cmd.act = ACT_HALT;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV_PER;
                end
            end
            S_DIV_PER: begin
                if (!i_stat.div_busy) begin
                    o_cmd.act = ACT_LAUNCH;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/ssrc_dp.sv
// Datapath: configuration, axis state, rate arithmetic and result register.
module ssrc_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ssrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssrc_pkg::CFG_W-1:0]     i_cfg_data,
    input  ssrc_pkg::t_in_item             i_in_data,
    input  ssrc_pkg::t_dp_cmd              i_cmd,
    output ssrc_pkg::t_dp_stat             o_stat,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ssrc_pkg::t_out_item            o_out_data
);
    import ssrc_pkg::*;

    // Configuration
    logic [SPR_W-1:0]   r_spr;
    logic [RATE_W-1:0]  r_min;
    logic [RATE_W-1:0]  r_max;
    logic [SETUP_W-1:0] r_setup;

    // Working registers of the current command
    t_in_item           r_item;
    logic [DIV_W-1:0]   r_prod;
    logic [QUO_W-1:0]   r_quo;
    logic [RATE_W-1:0]  r_rate;
    logic               r_cmd_dir;
    logic               r_cleared;

    // Axis state
    logic               r_running;
    logic               r_act_dir;
    logic               r_dir_pin;
    logic               r_pend;
    logic               r_pend_dir;
    logic [RATE_W-1:0]  r_pend_rate;
    logic [SETUP_W-1:0] r_cnt;
    logic [PER_W-1:0]   r_period;
    logic [HIGH_W-1:0]  r_high;

    logic               r_out_valid;
    t_out_item          r_out;

    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic [STEP_W-1:0]  div_steps;
    logic               div_busy;
    logic [DIV_W-1:0]   div_quot;
    logic [QPROD_W-1:0] quo_prod;
    logic [RATE_W-1:0]  rate_next;
    logic [PER_W-1:0]   per_sat;
    logic               out_free;

    ssrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    // The divider forms the period from the timer clock and the step rate.
    assign div_dividend = DIV_W'(TIMER_CLOCK_HZ) << PER_SHIFT;
    assign div_divisor  = DIV_W'(r_rate);
    assign div_steps    = STEP_W'(CLK_W);

    // The rounded product is divided by 60 through a reciprocal multiply.
    assign quo_prod = QPROD_W'(r_prod[DIV_W-1:RECIP_PRE]) * QPROD_W'(RECIP_15);

    // The minimum test comes before the clamp, so a rate below min_rate gives zero even if max_rate is lower.
    always_comb begin
        if (r_quo < QUO_W'(r_min)) begin
            rate_next = '0;
        end else if (r_quo > QUO_W'(r_max)) begin
            rate_next = r_max;
        end else begin
            rate_next = r_quo[RATE_W-1:0];
        end
    end

    always_comb begin
        if (div_quot < DIV_W'(PER_MIN)) begin
            per_sat = PER_W'(PER_MIN);
        end else if (div_quot > DIV_W'(PER_MAX)) begin
            per_sat = PER_W'(PER_MAX);
        end else begin
            per_sat = div_quot[PER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr   <= SPR_W'(SPR_RST);
            r_min   <= RATE_W'(MIN_RST);
            r_max   <= RATE_W'(MAX_RST);
            r_setup <= SETUP_W'(SETUP_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPR:   r_spr   <= i_cfg_data[SPR_W-1:0];
                CFG_MIN:   r_min   <= i_cfg_data[RATE_W-1:0];
                CFG_MAX:   r_max   <= i_cfg_data[RATE_W-1:0];
                CFG_SETUP: r_setup <= i_cfg_data[SETUP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item    <= i_in_data;
            r_cmd_dir <= i_in_data.direction;
            r_cleared <= 1'b0;
        end
        if (i_cmd.load_prod) begin
            r_prod <= DIV_W'(r_item.rpm_req) * DIV_W'(r_spr) + DIV_W'(RPM_ROUND);
        end
        if (i_cmd.load_quo) begin
            r_quo <= quo_prod[QPROD_W-1:RECIP_SHIFT];
        end
        if (i_cmd.load_rate) begin
            r_rate <= rate_next;
        end
        if (i_cmd.act == ACT_PEND_TAKE) begin
            r_rate    <= r_pend_rate;
            r_cmd_dir <= r_pend_dir;
        end
        if (i_cmd.act == ACT_LAUNCH) begin
            r_cleared <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_act_dir   <= 1'b0;
            r_dir_pin   <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_dir  <= 1'b0;
            r_pend_rate <= '0;
            r_cnt       <= '0;
            r_period    <= PER_W'(PER_MIN);
            r_high      <= '0;
        end else begin
            case (i_cmd.act)
                ACT_HALT: begin
                    r_running <= 1'b0;
                    r_pend    <= 1'b0;
                    r_cnt     <= '0;
                    r_high    <= '0;
                end
                ACT_REVERSE: begin
                    // Pulses stop and the direction pin changes at once; the new rate waits out setup.
                    r_running   <= 1'b0;
                    r_high      <= '0;
                    r_dir_pin   <= r_item.direction;
                    r_pend      <= 1'b1;
                    r_pend_dir  <= r_item.direction;
                    r_pend_rate <= r_rate;
                    r_cnt       <= r_setup;
                end
                ACT_COUNT: begin
                    r_cnt <= r_cnt - 1'b1;
                end
                ACT_PEND_TAKE: begin
                    r_pend <= 1'b0;
                end
                ACT_LAUNCH: begin
                    r_running <= 1'b1;
                    r_dir_pin <= r_cmd_dir;
                    r_act_dir <= r_cmd_dir;
                    r_period  <= per_sat;
                    r_high    <= per_sat[PER_W-1:1];
                end
                default: begin
                end
            endcase
        end
    end

    assign out_free = ~r_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.pulse_enable     <= r_running;
            r_out.dir_level        <= r_dir_pin;
            r_out.period_ticks     <= r_period;
            r_out.high_ticks       <= r_high;
            r_out.counter_cleared  <= r_cleared;
            r_out.reversal_pending <= r_pend;
        end
    end

    always_comb begin
        o_stat.req        = t_req'(r_item.req_type);
        o_stat.rate_zero  = (r_rate == '0);
        o_stat.running    = r_running;
        o_stat.dir_diff   = (r_item.direction != r_act_dir);
        o_stat.pend_valid = r_pend;
        o_stat.cnt_zero   = (r_cnt == '0);
        o_stat.div_busy   = div_busy;
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_high_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_high == r_period[PER_W-1:1]))
        else $error("high time is not half the period while running");

    a_stopped_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_high == '0))
        else $error("high time nonzero while stopped");

    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_period >= PER_W'(PER_MIN)) && (r_period <= PER_W'(PER_MAX)))
        else $error("period outside its saturation range");

    a_count_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> r_pend)
        else $error("setup countdown running without a pending command");

endmodule

FILE: rtl/stepper_step_rate_commander_core.sv
// Top level of one stepper axis step-rate commander.
//
// Commands enter on i_in (speed command, tick, or stop) and
// each one produces exactly one drive-settings item on o_out: pulse enable,
// direction pin level, period and high time in timer ticks, whether the
// period counter was restarted, and whether a reversal is pending.
// Registers are to be written through i_cfg_we / i_cfg_idx / i_cfg_data
// only while the block is idle, so that they affect later commands only;
// the block itself does not enforce this. One command is worked at a time. A
// speed command that starts the axis runs the bit-serial divider that forms
// the period; one that stops or reverses the axis skips it. A tick that
// starts a pending command also runs the divider; other items skip it.
// i_in.ready is high while the sequencer is idle, so the next transfer can
// come in the cycle after the sequencer loads the result register. The result register
// decouples the two sides: a new command is accepted while the previous
// result still waits. If that result is still held when the next one is
// ready, the sequencer waits for it and i_in stays blocked meanwhile.
// Reset (synchronous, active low) stops the axis, clears any pending
// reversal and restores the default configuration.
module stepper_step_rate_commander_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ssrc_in_if.sink                        i_in,
    ssrc_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [ssrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssrc_pkg::CFG_W-1:0]     i_cfg_data
);
    import ssrc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;

    ssrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    ssrc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in.data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

    assign i_in.ready = in_ready;

endmodule
